@@ src/tcbf_pkg.sv @@
// ----------------------------------------------------------------------------
// Text chunk boundary finder package
// Request types, register indexes and shared constants of the chunk finder.
// ----------------------------------------------------------------------------
`default_nettype none

package tcbf_pkg;

	// Largest chunk length the newline ring is built for.
	localparam int unsigned MAX_CHUNK_DEFAULT = 4095;

	// Configuration port geometry.
	localparam int unsigned CFG_W  = 12;
	localparam int unsigned CFG_IW = 1;

	// Register indexes.
	localparam logic [CFG_IW-1:0] REG_CHUNK_SIZE    = 1'd0;
	localparam logic [CFG_IW-1:0] REG_CHUNK_OVERLAP = 1'd1;

	// Chunk size used when the size register holds zero.
	localparam logic [CFG_W-1:0] DEFAULT_SIZE = 12'd2048;

	// Byte code of a line break.
	localparam logic [7:0] NEWLINE_CODE = 8'd10;

	// One input request: a text byte and the last-byte flag.
	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} in_item_t;

	// One result request: a chunk descriptor or an error marker.
	typedef struct packed {
		logic [31:0] chunk_start;
		logic [31:0] chunk_end;
		logic        final_chunk;
		logic        error_flag;
	} out_item_t;

endpackage

`default_nettype wire

@@ src/tcbf_ring.sv @@
// ----------------------------------------------------------------------------
// Newline mark ring
// One-bit memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tcbf_ring #(
	parameter int unsigned DEPTH = tcbf_pkg::MAX_CHUNK_DEFAULT + 1,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic          wdata,
	input  wire logic [AW-1:0] raddr,
	output logic               rdata
);

	logic mem [DEPTH];

	// Write the mark of the newest byte; read the addressed mark every cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ src/text_chunk_boundary_finder_core.sv @@
// ----------------------------------------------------------------------------
// Text chunk boundary finder
// Splits a byte stream into overlapping chunks and reports their offsets.
// ----------------------------------------------------------------------------
// Usage:
// Text bytes enter on the in channel (valid/ready), one request per byte,
// with end_of_text set on the last byte of a text. Chunk descriptors leave
// on the out channel (valid/ready) through a single output register.
// Two registers set the target chunk size and the overlap; write them only
// while the block is idle.
// A byte that settles no chunk is accepted and then evaluated. When a chunk
// settles, a newline search walks the ring of newline marks backward from
// the target length, one mark at a time through the ring's registered read
// port: each mark is read, then checked. At most two chunks settle per byte.
// in_ready is high only while the sequencer is idle; a result waiting in
// the output register does not block it.
// If the receiver stalls, the sequencer holds in the state that produces
// the next result until the output register is free.
// Reset clears the position counters and error state; the ring needs no
// clearing pass, since every mark that is read was written earlier.
// ----------------------------------------------------------------------------
`default_nettype none

module text_chunk_boundary_finder_core #(
	parameter int unsigned MAX_CHUNK = tcbf_pkg::MAX_CHUNK_DEFAULT
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_write,
	input  wire logic [tcbf_pkg::CFG_IW-1:0]    cfg_index,
	input  wire logic [tcbf_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire tcbf_pkg::in_item_t             in_data,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output tcbf_pkg::out_item_t                 out_data
);

	localparam int unsigned DEPTH = MAX_CHUNK + 1;
	localparam int unsigned AW    = $clog2(DEPTH);
	localparam int unsigned LW    = AW + 1;
	localparam logic [LW-1:0] DEPTH_L = LW'(DEPTH);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_ERR   = 6'b000010,
		S_EVAL  = 6'b000100,
		S_SRD   = 6'b001000,
		S_SCHK  = 6'b010000,
		S_CHUNK = 6'b100000
	} state_t;

	state_t state_q;

	logic [tcbf_pkg::CFG_W-1:0] chunk_size_q;
	logic [tcbf_pkg::CFG_W-1:0] chunk_overlap_q;
	logic [tcbf_pkg::CFG_W-1:0] ovl_q;
	logic [31:0]                bytes_seen_q;
	logic [31:0]                ws_q;
	logic [AW-1:0]              ws_idx_q;
	logic [AW-1:0]              wr_idx_q;
	logic [AW-1:0]              rd_addr_q;
	logic [LW-1:0]              i_q;
	logic [LW-1:0]              len_q;
	logic [LW-1:0]              target_q;
	logic                       last_q;
	logic                       round_q;
	logic                       failed_q;
	logic                       out_valid_q;
	tcbf_pkg::out_item_t        out_q;

	logic                       accept;
	logic                       slot_free;
	logic [tcbf_pkg::CFG_W-1:0] size_sel;
	logic [LW-1:0]              target_w;
	logic                       bad;
	logic [31:0]                remaining;
	logic                       over;
	logic [LW-1:0]              start_sum;
	logic [AW-1:0]              start_idx;
	logic [LW-1:0]              half;
	logic                       last_mark;
	logic [31:0]                len32;
	logic [31:0]                step;
	logic [LW-1:0]              ws_idx_sum;
	logic [AW-1:0]              ws_idx_next;
	logic [AW-1:0]              wr_idx_next;
	logic [AW-1:0]              rd_addr_prev;
	logic                       ring_we;
	logic                       ring_bit;
	logic                       out_load;
	tcbf_pkg::out_item_t        out_next;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Effective target length: zero selects the default, capped at MAX_CHUNK.
	always_comb begin
		size_sel = (chunk_size_q == '0) ? tcbf_pkg::DEFAULT_SIZE : chunk_size_q;
		if (32'(size_sel) > 32'(MAX_CHUNK)) begin
			target_w = LW'(MAX_CHUNK);
		end else begin
			target_w = LW'(size_sel);
		end
		bad = (32'(chunk_overlap_q) >= 32'(target_w)) || (bytes_seen_q == '1);
	end

	// A chunk is settled once more than target bytes follow the window start.
	assign remaining = bytes_seen_q - ws_q;
	assign over      = remaining > 32'(target_q);

	// Ring position of the first mark to test, and the walk downward.
	assign start_sum    = {1'b0, ws_idx_q} + target_q;
	assign start_idx    = (start_sum >= DEPTH_L) ? AW'(start_sum - DEPTH_L) : AW'(start_sum);
	assign rd_addr_prev = (rd_addr_q == '0) ? LAST_IDX : rd_addr_q - AW'(1);
	assign half         = target_q >> 1;
	assign last_mark    = (i_q <= half + LW'(1));

	// Chunk length after the minimum-length rule, and the window advance.
	always_comb begin
		if (32'(len_q) <= 32'(ovl_q)) begin
			len32 = 32'(ovl_q) + 32'd1;
		end else begin
			len32 = 32'(len_q);
		end
		step        = len32 - 32'(ovl_q);
		ws_idx_sum  = LW'(32'(ws_idx_q) + step);
		ws_idx_next = (ws_idx_sum >= DEPTH_L) ? AW'(ws_idx_sum - DEPTH_L) : AW'(ws_idx_sum);
	end

	assign wr_idx_next = (wr_idx_q == LAST_IDX) ? '0 : wr_idx_q + AW'(1);
	assign ring_we     = accept && !failed_q && !bad;

	tcbf_ring #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ring (
		.clk   (clk),
		.we    (ring_we),
		.waddr (wr_idx_q),
		.wdata (in_data.text_byte == tcbf_pkg::NEWLINE_CODE),
		.raddr (rd_addr_q),
		.rdata (ring_bit)
	);

	// Result to place in the output register this cycle, if any.
	always_comb begin
		out_load = 1'b0;
		out_next = '0;
		case (state_q)
			S_ERR: begin
				out_load            = slot_free;
				out_next.error_flag = 1'b1;
			end
			S_EVAL: begin
				if (!over && last_q) begin
					out_load             = slot_free;
					out_next.chunk_start = ws_q;
					out_next.chunk_end   = bytes_seen_q;
					out_next.final_chunk = 1'b1;
				end
			end
			S_CHUNK: begin
				out_load             = slot_free;
				out_next.chunk_start = ws_q;
				out_next.chunk_end   = ws_q + len32;
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= out_next;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_size_q    <= '0;
			chunk_overlap_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				tcbf_pkg::REG_CHUNK_SIZE:    chunk_size_q    <= cfg_data;
				tcbf_pkg::REG_CHUNK_OVERLAP: chunk_overlap_q <= cfg_data;
				default: begin
					chunk_size_q <= chunk_size_q;
				end
			endcase
		end
	end

	// Sequencer: accept, evaluate, search the ring, emit chunks and error markers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			bytes_seen_q <= '0;
			ws_q         <= '0;
			ws_idx_q     <= '0;
			wr_idx_q     <= '0;
			rd_addr_q    <= '0;
			i_q          <= '0;
			len_q        <= '0;
			target_q     <= '0;
			ovl_q        <= '0;
			last_q       <= 1'b0;
			round_q      <= 1'b0;
			failed_q     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						last_q <= in_data.end_of_text;
						if (failed_q) begin
							// Bytes after an error are dropped until the text ends.
							if (in_data.end_of_text) begin
								bytes_seen_q <= '0;
								ws_q         <= '0;
								ws_idx_q     <= '0;
								wr_idx_q     <= '0;
								failed_q     <= 1'b0;
							end
						end else if (bad) begin
							state_q <= S_ERR;
						end else begin
							bytes_seen_q <= bytes_seen_q + 32'd1;
							wr_idx_q     <= wr_idx_next;
							target_q     <= target_w;
							ovl_q        <= chunk_overlap_q;
							round_q      <= 1'b0;
							state_q      <= S_EVAL;
						end
					end
				end
				S_ERR: begin
					if (slot_free) begin
						if (last_q) begin
							bytes_seen_q <= '0;
							ws_q         <= '0;
							ws_idx_q     <= '0;
							wr_idx_q     <= '0;
							failed_q     <= 1'b0;
						end else begin
							failed_q <= 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				S_EVAL: begin
					if (over) begin
						rd_addr_q <= start_idx;
						i_q       <= target_q;
						state_q   <= S_SRD;
					end else if (last_q) begin
						// Rest of the text forms the final chunk.
						if (slot_free) begin
							bytes_seen_q <= '0;
							ws_q         <= '0;
							ws_idx_q     <= '0;
							wr_idx_q     <= '0;
							state_q      <= S_IDLE;
						end
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_SRD: begin
					state_q <= S_SCHK;
				end
				S_SCHK: begin
					if (ring_bit) begin
						len_q   <= i_q + LW'(1);
						state_q <= S_CHUNK;
					end else if (last_mark) begin
						len_q   <= target_q;
						state_q <= S_CHUNK;
					end else begin
						i_q       <= i_q - LW'(1);
						rd_addr_q <= rd_addr_prev;
						state_q   <= S_SRD;
					end
				end
				S_CHUNK: begin
					if (slot_free) begin
						if (round_q) begin
							// Two chunks settled; the byte is done.
							if (last_q) begin
								bytes_seen_q <= '0;
								ws_q         <= '0;
								ws_idx_q     <= '0;
								wr_idx_q     <= '0;
							end else begin
								ws_q     <= ws_q + step;
								ws_idx_q <= ws_idx_next;
							end
							state_q <= S_IDLE;
						end else begin
							ws_q     <= ws_q + step;
							ws_idx_q <= ws_idx_next;
							round_q  <= 1'b1;
							state_q  <= S_EVAL;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
